// ===== sv/clhe_pkg.sv =====
// clamped histogram engine: shared types and constants
// item operation codes, bin store entry layout, result layout, control states
// no dependencies
package clhe_pkg;

  // fixed field widths
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned SEL_W   = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned NUM_W   = 8;
  // width of the image generation tag kept with every bin
  localparam int unsigned EPOCH_W = 8;

  // register indexes of the configuration port
  localparam logic CFG_MIN_VALUE = 1'b0;
  localparam logic CFG_MAX_VALUE = 1'b1;

  // item operations
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // control states
  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } state_e;

  // one bin of the store: generation tag and saturating count
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // one result item, count in the low bits
  typedef struct packed {
    logic [NUM_W-1:0]   number;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ===== sv/clamped_histogram_engine_unit.sv =====
// clamped histogram engine: top level
// control, read-modify-write pipeline with forwarding, configuration registers
// depends on clhe_pkg, clhe_bin_map, clhe_bin_ram, clhe_out_fifo
//
// Usage:
//   Input channel s_axis: tuser carries the operation (clear, count, read),
//   tdata carries the pixel and the bin to read. Output channel m_axis gives
//   one item per read: the bin count and the bin number.
//   Configuration: cfg_we_i writes min_value (index 0) or max_value (index 1);
//   the user must write only while the block is idle; the block does not enforce it.
// Throughput: one item per cycle while s_axis_tready is high. A count item reads its
//   bin when accepted and writes it back in the next cycle; a back-to-back count of
//   the same bin takes the new value from a forwarding register, not the memory port.
// A read item passes the modify stage and the result queue before it reaches m_axis.
// Clearing: a clear item bumps an 8-bit image tag, so bins tagged with an
//   older image read as zero. Every 255th clear, and after reset, the block
//   sweeps the store, one bin a cycle, with tready low.
// Stall: results queue in a two-entry buffer; when it would overflow,
//   s_axis_tready drops until the receiver takes items again.
module clamped_histogram_engine_unit #(
  parameter int unsigned BINS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] pixel, [23:16] bin_select
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] bin_count, [39:32] bin_number
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import clhe_pkg::*;

  localparam int unsigned BIN_W = (BINS > 2) ? $clog2(BINS) : 1;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // configuration registers
  logic signed [PIX_W-1:0] min_value_q;
  logic signed [PIX_W-1:0] max_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q <= 16'sd0;
      max_value_q <= 16'sd255;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MIN_VALUE: min_value_q <= cfg_wdata_i;
        CFG_MAX_VALUE: max_value_q <= cfg_wdata_i;
        default:       min_value_q <= min_value_q;
      endcase
    end
  end

  // input decode
  op_e                     in_op;
  logic                    accept;
  logic signed [PIX_W-1:0] in_pixel;
  logic [SEL_W-1:0]        in_sel;
  logic [BIN_W-1:0]        in_idx;
  logic                    in_touch;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_pixel = s_axis_tdata[15:0];
  assign in_sel   = s_axis_tdata[23:16];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_touch = accept && (in_op == OP_COUNT || in_op == OP_READ);

  clhe_bin_map #(
    .BINS  (BINS),
    .BIN_W (BIN_W)
  ) u_bin_map (
    .is_read_i    (in_op == OP_READ),
    .pixel_i      (in_pixel),
    .bin_select_i (in_sel),
    .min_value_i  (min_value_q),
    .max_value_i  (max_value_q),
    .idx_o        (in_idx)
  );

  // control state
  state_e             state_q, state_d;
  logic [BIN_W-1:0]   sweep_q, sweep_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               sweeping;

  always_comb begin
    state_d  = state_q;
    sweep_d  = sweep_q;
    epoch_d  = epoch_q;
    sweeping = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        sweeping = 1'b1;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_q == LAST_BIN) begin
          state_d = ST_RUN;
          sweep_d = '0;
          epoch_d = EPOCH_FIRST;
        end
      end
      ST_RUN: begin
        if (accept && in_op == OP_CLEAR) begin
          if (&epoch_q) begin
            state_d = ST_SWEEP;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      sweep_q <= '0;
      epoch_q <= EPOCH_FIRST;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      epoch_q <= epoch_d;
    end
  end

  // modify stage registers
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [BIN_W-1:0] s1_idx_q;
  logic             fwd_q, fwd_d;
  entry_t           fwd_data_q;

  // modify stage: pick forwarded or stored entry and bump the count
  entry_t             rd_entry;
  entry_t             cur;
  entry_t             new_entry;
  logic               hit;
  logic [COUNT_W-1:0] old_cnt;
  logic               s1_wr;
  logic               s1_rd;

  always_comb begin
    cur             = fwd_q ? fwd_data_q : rd_entry;
    hit             = (cur.epoch == epoch_q);
    old_cnt         = hit ? cur.count : '0;
    new_entry.epoch = epoch_q;
    if (!hit) begin
      new_entry.count = COUNT_W'(1);
    end else if (&old_cnt) begin
      new_entry.count = old_cnt;
    end else begin
      new_entry.count = old_cnt + 1'b1;
    end
    s1_wr = s1_valid_q && (s1_op_q == OP_COUNT);
    s1_rd = s1_valid_q && (s1_op_q == OP_READ);
    fwd_d = in_touch && s1_wr && (in_idx == s1_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_touch;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_touch) begin
      s1_op_q  <= in_op;
      s1_idx_q <= in_idx;
    end
    fwd_data_q <= new_entry;
  end

  // store write port shared by the sweep and the write-back
  logic             mem_we;
  logic [BIN_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  always_comb begin
    if (sweeping) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_wr;
      mem_waddr = s1_idx_q;
      mem_wdata = new_entry;
    end
  end

  clhe_bin_ram #(
    .BINS  (BINS),
    .BIN_W (BIN_W)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_touch),
    .raddr_i (in_idx),
    .rdata_o (rd_entry)
  );

  // result queue
  result_t    push_data;
  result_t    out_data;
  logic       out_valid;
  logic       pop;
  logic [1:0] out_count;
  logic [15:0] idx_wide;
  logic [2:0] pending;
  logic [2:0] room;

  assign idx_wide         = 16'(s1_idx_q);
  assign push_data.number = idx_wide[NUM_W-1:0];
  assign push_data.count  = old_cnt;
  assign pop              = out_valid && m_axis_tready;

  clhe_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_rd),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid),
    .data_o      (out_data),
    .count_o     (out_count)
  );

  // accept only when a read taken now is sure to find room in the queue
  assign pending       = 3'(out_count) + 3'(s1_rd);
  assign room          = 3'd2 + 3'(pop);
  assign s_axis_tready = (state_q == ST_RUN) && (pending < room);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== sv/clhe_bin_map.sv =====
// clamped histogram engine: pixel and bin number to bin index
// clamps the pixel into min..max, offsets by min and saturates to the last bin
// depends on clhe_pkg
module clhe_bin_map #(
  parameter int unsigned BINS  = 256,
  parameter int unsigned BIN_W = 8
) (
  input  logic                        is_read_i,
  input  logic signed [clhe_pkg::PIX_W-1:0] pixel_i,
  input  logic [clhe_pkg::SEL_W-1:0]  bin_select_i,
  input  logic signed [clhe_pkg::PIX_W-1:0] min_value_i,
  input  logic signed [clhe_pkg::PIX_W-1:0] max_value_i,
  output logic [BIN_W-1:0]            idx_o
);
  import clhe_pkg::*;

  localparam logic [PIX_W:0] LAST = (PIX_W+1)'(BINS - 1);

  logic signed [PIX_W-1:0] upper;
  logic signed [PIX_W-1:0] clamped;
  logic signed [PIX_W:0]   diff;
  logic [PIX_W:0]          pix_off;
  logic [PIX_W:0]          sel_ext;
  logic [PIX_W:0]          raw;
  logic [PIX_W:0]          sat;

  // upper clamp first, then lower clamp so min always wins
  always_comb begin
    upper   = (pixel_i > max_value_i) ? max_value_i : pixel_i;
    clamped = (upper < min_value_i) ? min_value_i : upper;
    diff    = {clamped[PIX_W-1], clamped} - {min_value_i[PIX_W-1], min_value_i};
    pix_off = {1'b0, diff[PIX_W-1:0]};
    sel_ext = (PIX_W+1)'(bin_select_i);
    raw     = is_read_i ? sel_ext : pix_off;
    sat     = (raw > LAST) ? LAST : raw;
    idx_o   = sat[BIN_W-1:0];
  end

endmodule

// ===== sv/clhe_bin_ram.sv =====
// clamped histogram engine: bin store
// one write port and one read port, read data registered, old data on collision
// depends on clhe_pkg
module clhe_bin_ram #(
  parameter int unsigned BINS  = 256,
  parameter int unsigned BIN_W = 8
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [BIN_W-1:0]       waddr_i,
  input  clhe_pkg::entry_t       wdata_i,
  input  logic                   re_i,
  input  logic [BIN_W-1:0]       raddr_i,
  output clhe_pkg::entry_t       rdata_o
);
  import clhe_pkg::*;

  entry_t mem [BINS];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/clhe_out_fifo.sv =====
// clamped histogram engine: two-entry result queue in front of the output channel
// decouples the read pipeline from a stalling receiver
// depends on clhe_pkg
module clhe_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clhe_pkg::result_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output clhe_pkg::result_t data_o,
  output logic [1:0]        count_o
);
  import clhe_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
